// ===== hdl/klt_pkg.sv =====
// Shared types and constants of the keyed list table.
// Holds the status and operation codes and the control/status bundles
// that join the controller and the datapath. No dependencies.
package klt_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_SEARCH = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // Source of the reported position.
    typedef enum logic [1:0] {
        POS_ZERO = 2'd0,
        POS_HIT  = 2'd1,
        POS_MISS = 2'd2
    } pos_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;        // capture the input word, clear the index
        logic     rd_cur;      // read the entry at the index
        logic     rd_next;     // read the entry after the index
        logic     idx_inc;     // step the index
        logic     wr_shift;    // write the read entry at the index, step it
        logic     append;      // write the input entry at the end
        logic     dec_count;   // one entry fewer
        logic     set_result;  // capture the pending result
        status_t  res_code;
        pos_sel_t pos_sel;
        logic     out_load;    // move the pending result to the output
    } klt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       count_zero;
        logic       count_full;
        logic       hit;         // read key equals the requested key
        logic       last;        // index is the last held entry
        logic       shift_last;  // entry after the index is the last one
        logic       out_free;    // output register can take a word
    } klt_stat_t;

endpackage

// ===== hdl/keyed_list_table_unit.sv =====
// Keyed list table: search, insert and remove on up to CAPACITY key/value
// entries kept in insertion order. Built from klt_ctrl and klt_datapath.
//
// Usage: one request word enters on the s_ channel; op travels on s_tuser
// (0 search, 1 insert, 2 remove), key and value on s_tdata. Each request
// gives exactly one result word on the m_ channel: status, position and
// the number of entries held afterwards.
// Sequence: one request is worked at a time. The scan reads and compares the
// entries one by one, each read then compared, through a single memory read
// port; a remove that hits before the last entry then moves each later entry
// down one place, each read then written. The result word shows in the same
// cycle in which the next request can be taken.
// An empty table or an unused op code skips the scan and goes from dispatch
// straight to the result.
// Reset empties the table; entry contents are not cleared.
// A result waits in the output register while m_tready is low; the next
// request is taken meanwhile and held at its result until the register
// frees up.
module keyed_list_table_unit
    import klt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key[31:0], entry_value[63:32]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[2:0], position[7:3], entry_count[12:8]
);

    klt_cmd_t   cmd;
    klt_stat_t  stat;
    logic       ctrl_ready;
    logic [2:0] out_status;
    logic [4:0] out_position;
    logic [4:0] out_count;

    // Sequencer.
    klt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (ctrl_ready)
    );

    // Storage, compare and result registers.
    klt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_op        (s_tuser),
        .in_key       (s_tdata[31:0]),
        .in_value     (s_tdata[63:32]),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (out_status),
        .out_position (out_position),
        .out_count    (out_count)
    );

    assign s_tready = ctrl_ready;
    assign m_tdata  = {3'b000, out_count, out_position, out_status};

`ifndef NO_ASSERTIONS
    // Only one request is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in work");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= ST_EMPTY))
        else $error("undefined status code");

    // A full, duplicate or empty result reports no position.
    a_pos_only_search: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:0] == ST_FULL || m_tdata[2:0] == ST_DUPLICATE
            || m_tdata[2:0] == ST_EMPTY)) |-> (m_tdata[7:3] == 5'd0))
        else $error("position reported for a failed insert or remove");
`endif

endmodule

// ===== hdl/klt_ctrl.sv =====
// Controller state machine of the keyed list table.
// Sequences scan, append and shift steps of the datapath; uses klt_pkg.
module klt_ctrl
    import klt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  klt_stat_t stat,
    output klt_cmd_t  cmd,
    output logic      in_ready
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_SCAN_RD  = 7'b0000100,
        S_SCAN_CMP = 7'b0001000,
        S_SHIFT_RD = 7'b0010000,
        S_SHIFT_WR = 7'b0100000,
        S_RESULT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                // Wait here until a request word is offered.
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_RESULT;
                cmd.set_result = 1'b1;
                cmd.res_code = ST_OK;
                cmd.pos_sel = POS_ZERO;
                unique case (stat.op)
                    OP_SEARCH:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.res_code = ST_NOT_FOUND;
                            cmd.pos_sel = POS_MISS;
                        end
                        else
                        begin
                            cmd.set_result = 1'b0;
                            state_next = S_SCAN_RD;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.append = 1'b1;
                        end
                        else
                        begin
                            cmd.set_result = 1'b0;
                            state_next = S_SCAN_RD;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.res_code = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.set_result = 1'b0;
                            state_next = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        // Unused code: no change, plain ok result.
                        cmd.res_code = ST_OK;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                cmd.set_result = 1'b1;
                cmd.res_code = ST_OK;
                cmd.pos_sel = POS_ZERO;
                state_next = S_RESULT;
                if (stat.hit)
                begin
                    unique case (stat.op)
                        OP_SEARCH: cmd.pos_sel = POS_HIT;
                        OP_INSERT: cmd.res_code = ST_DUPLICATE;
                        OP_REMOVE:
                        begin
                            if (stat.last)
                            begin
                                cmd.dec_count = 1'b1;
                            end
                            else
                            begin
                                cmd.set_result = 1'b0;
                                state_next = S_SHIFT_RD;
                            end
                        end
                        default: cmd.res_code = ST_OK;
                    endcase
                end
                else if (stat.last)
                begin
                    unique case (stat.op)
                        OP_SEARCH:
                        begin
                            cmd.res_code = ST_NOT_FOUND;
                            cmd.pos_sel = POS_MISS;
                        end
                        OP_INSERT:
                        begin
                            if (stat.count_full)
                            begin
                                cmd.res_code = ST_FULL;
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                            end
                        end
                        OP_REMOVE: cmd.res_code = ST_NOT_FOUND;
                        default:   cmd.res_code = ST_OK;
                    endcase
                end
                else
                begin
                    cmd.set_result = 1'b0;
                    cmd.idx_inc = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.rd_next = 1'b1;
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                if (stat.shift_last)
                begin
                    cmd.dec_count = 1'b1;
                    cmd.set_result = 1'b1;
                    cmd.res_code = ST_OK;
                    cmd.pos_sel = POS_ZERO;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/klt_datapath.sv =====
// Datapath of the keyed list table: entry memories, index and count,
// key compare, pending result and output register. Uses klt_pkg.
module klt_datapath
    import klt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      in_op,
    input  logic [31:0]     in_key,
    input  logic [31:0]     in_value,
    input  klt_cmd_t        cmd,
    output klt_stat_t       stat,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2:0]      out_status,
    output logic [4:0]      out_position,
    output logic [4:0]      out_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY + 2);

    logic [31:0]   key_mem [CAPACITY];
    logic [31:0]   val_mem [CAPACITY];

    logic [1:0]    op_reg;
    logic [31:0]   key_reg;
    logic [31:0]   val_reg;
    logic [31:0]   rd_key_reg;
    logic [31:0]   rd_val_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] count_reg;
    status_t       res_status_reg;
    logic [PW-1:0] res_pos_reg;
    logic          out_valid_reg;
    logic [2:0]    out_status_reg;
    logic [PW-1:0] out_pos_reg;
    logic [CW-1:0] out_count_reg;

    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_key;
    logic [31:0]   wr_val;
    logic          wr_en;
    logic [CW:0]   idx_plus1;
    logic [CW:0]   idx_plus2;
    logic [PW-1:0] pos_value;

    // Input word capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_op;
            key_reg <= in_key;
            val_reg <= in_value;
        end
    end

    // Memory addressing: scan reads at the index, shift reads one above.
    assign rd_addr = cmd.rd_next ? IW'(idx_reg + CW'(1)) : idx_reg[IW-1:0];
    assign wr_en   = cmd.append | cmd.wr_shift;
    assign wr_addr = cmd.append ? count_reg[IW-1:0] : idx_reg[IW-1:0];
    assign wr_key  = cmd.append ? key_reg : rd_key_reg;
    assign wr_val  = cmd.append ? val_reg : rd_val_reg;

    // Entry memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        if (cmd.rd_cur || cmd.rd_next)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_val_reg <= val_mem[rd_addr];
        end
    end

    // Index and entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc || cmd.wr_shift)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.append)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.dec_count)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Status toward the controller.
    assign idx_plus1 = {1'b0, idx_reg} + (CW+1)'(1);
    assign idx_plus2 = {1'b0, idx_reg} + (CW+1)'(2);

    always_comb
    begin
        stat.op         = op_reg;
        stat.count_zero = (count_reg == '0);
        stat.count_full = (count_reg == CW'(CAPACITY));
        stat.hit        = (rd_key_reg == key_reg);
        stat.last       = (idx_plus1 == {1'b0, count_reg});
        stat.shift_last = (idx_plus2 == {1'b0, count_reg});
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // Position for the pending result.
    always_comb
    begin
        unique case (cmd.pos_sel)
            POS_HIT:  pos_value = PW'(idx_plus1);
            POS_MISS: pos_value = PW'(CAPACITY + 1);
            default:  pos_value = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_result)
        begin
            res_status_reg <= cmd.res_code;
            res_pos_reg    <= pos_value;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_pos_reg    <= res_pos_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_position = 5'(out_pos_reg);
    assign out_count    = 5'(out_count_reg);

endmodule

// ===== tb/keyed_list_table_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for keyed_list_table_unit: a directed table with its own expected
// words, and random search/insert/remove/unused-code traffic checked against a table model.
// Depends on klt_pkg and keyed_list_table_unit.
module keyed_list_table_unit_tb;
    import klt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int KEY_POOL_SIZE = 24;
    localparam int SEGMENT_WORDS = 50;
    localparam int SEGMENTS = 17;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT = 1000;
    localparam int MAX_REPORTS = 10;

    typedef enum int { MODE_FILL, MODE_MIXED, MODE_DRAIN } traffic_mode_t;

    typedef struct packed {
        status_t    status;
        logic [4:0] position;
        logic [4:0] entry_count;
    } table_result_t;

    typedef struct packed {
        logic [1:0]    op;
        logic [31:0]   key;
        logic [31:0]   value;
        bit            typed;
        table_result_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // key[31:0], entry_value[63:32]
    logic [1:0]  s_tuser;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // status[2:0], position[7:3], entry_count[12:8]

    // Model of the table contents and the words still owed by the block.
    logic [31:0]   held_keys [TABLE_DEPTH];
    int            held_count;
    table_result_t pending_results[$];
    logic [31:0]   key_pool [KEY_POOL_SIZE];
    stim_row_t     directed_rows[$];
    int            mismatches;
    int            idle_cycles;
    bit            quiet_phase;

    keyed_list_table_unit #(
        .CAPACITY(TABLE_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one operation to the table model and return the word it should produce.
    function automatic table_result_t table_apply(logic [1:0] op, logic [31:0] key);
        table_result_t res;
        int hit;
        res.status = ST_OK;
        res.position = 5'd0;
        hit = 0;
        for (int p = 1; p <= held_count; p++)
        begin
            if (hit == 0 && held_keys[p - 1] == key)
                hit = p;
        end
        case (op)
            OP_SEARCH:
            begin
                if (hit != 0)
                    res.position = 5'(hit);
                else
                begin
                    res.status = ST_NOT_FOUND;
                    res.position = 5'(TABLE_DEPTH + 1);
                end
            end
            OP_INSERT:
            begin
                if (hit != 0)
                    res.status = ST_DUPLICATE;
                else if (held_count >= TABLE_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    held_keys[held_count] = key;
                    held_count++;
                end
            end
            OP_REMOVE:
            begin
                if (held_count == 0)
                    res.status = ST_EMPTY;
                else if (hit == 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    // Close the gap: every later entry moves down one place.
                    for (int a = hit - 1; a < held_count - 1; a++)
                        held_keys[a] = held_keys[a + 1];
                    held_count--;
                end
            end
            default:
            begin
            end
        endcase
        res.entry_count = 5'(held_count);
        return res;
    endfunction

    function automatic stim_row_t table_row(logic [1:0] op, logic [31:0] key,
                                            logic [31:0] value, bit typed,
                                            status_t st, int pos, int cnt);
        stim_row_t row;
        row.op = op;
        row.key = key;
        row.value = value;
        row.typed = typed;
        row.want.status = st;
        row.want.position = 5'(pos);
        row.want.entry_count = 5'(cnt);
        return row;
    endfunction

    function automatic logic [31:0] fill_key(int i);
        case (i)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h5A5A_0000 | 32'(i);
        endcase
    endfunction

    // Pick a key: often one held in the table, else from a small pool, else anything.
    function automatic logic [31:0] pick_key(int held_bias);
        if (held_count > 0 && $urandom_range(0, 99) < held_bias)
            return held_keys[$urandom_range(0, held_count - 1)];
        if ($urandom_range(0, 99) < 80)
            return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // Offer one request word, wait for the handshake, then record the owed result.
    task automatic send_word(input stim_row_t row);
        int gap;
        table_result_t predicted;
        gap = quiet_phase ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {row.value, row.key};
        s_tuser <= row.op;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = table_apply(row.op, row.key);
        pending_results.push_back(row.typed ? row.want : predicted);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus: reset, directed table, then random segments of traffic.
    initial
    begin
        traffic_mode_t mode;
        int roll;
        logic [1:0] op;
        logic [31:0] key;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        rst_n <= 1'b0;
        held_count = 0;
        mismatches = 0;
        quiet_phase = 1'b0;
        for (int i = 0; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // Empty table, the unused op code, a fill to capacity with extreme keys, then full,
        // duplicate-on-full, last- and first-position search, remove and not-found cases.
        directed_rows.push_back(table_row(OP_SEARCH, 32'h0, 32'h0, 1, ST_NOT_FOUND,
                                          TABLE_DEPTH + 1, 0));
        directed_rows.push_back(table_row(OP_REMOVE, 32'h0, 32'h0, 1, ST_EMPTY, 0, 0));
        directed_rows.push_back(table_row(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                                          ST_OK, 0, 0));
        for (int i = 0; i < TABLE_DEPTH; i++)
            directed_rows.push_back(table_row(OP_INSERT, fill_key(i),
                                              (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                                              1, ST_OK, 0, i + 1));
        directed_rows.push_back(table_row(OP_INSERT, 32'h1234_5678, 32'hFFFF_FFFF, 1,
                                          ST_FULL, 0, TABLE_DEPTH));
        directed_rows.push_back(table_row(OP_INSERT, fill_key(1), 32'h0, 1,
                                          ST_DUPLICATE, 0, TABLE_DEPTH));
        directed_rows.push_back(table_row(OP_SEARCH, fill_key(TABLE_DEPTH - 1), 32'h0, 1,
                                          ST_OK, TABLE_DEPTH, TABLE_DEPTH));
        directed_rows.push_back(table_row(OP_SEARCH, fill_key(0), 32'h0, 1,
                                          ST_OK, 1, TABLE_DEPTH));
        directed_rows.push_back(table_row(OP_REMOVE, fill_key(0), 32'h0, 1,
                                          ST_OK, 0, TABLE_DEPTH - 1));
        directed_rows.push_back(table_row(OP_SEARCH, fill_key(TABLE_DEPTH - 1), 32'h0, 0,
                                          ST_OK, 0, 0));
        directed_rows.push_back(table_row(OP_REMOVE, 32'h1234_5678, 32'h0, 1,
                                          ST_NOT_FOUND, 0, TABLE_DEPTH - 1));
        directed_rows.push_back(table_row(OP_SEARCH, 32'h1234_5678, 32'h0, 1,
                                          ST_NOT_FOUND, TABLE_DEPTH + 1, TABLE_DEPTH - 1));
        directed_rows.push_back(table_row(OP_UNUSED, 32'h0, 32'h0, 0, ST_OK, 0, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i]);
        wait_drained();

        // Random traffic: segments that fill, mix and drain the table in turn.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            mode = traffic_mode_t'(seg % 3);
            quiet_phase = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < SEGMENT_WORDS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll >= 95)
                    op = OP_UNUSED;
                else if (roll >= 55 && roll < 80)
                    op = OP_SEARCH;
                else if (mode == MODE_FILL)
                    op = (roll < 55) ? OP_INSERT : OP_REMOVE;
                else if (mode == MODE_DRAIN)
                    op = (roll < 55) ? OP_REMOVE : OP_INSERT;
                else
                    op = (roll < 30) ? OP_INSERT : OP_REMOVE;
                case (op)
                    OP_SEARCH: key = pick_key(60);
                    OP_REMOVE: key = pick_key(70);
                    OP_INSERT: key = pick_key(20);
                    default:   key = $urandom;
                endcase
                send_word(table_row(op, key, $urandom, 0, ST_OK, 0, 0));
            end
            if (seg % 5 == 4)
                wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("keyed_list_table_unit verification clean");
        else
            $display("keyed_list_table_unit verification failed");
        $finish;
    end

    // Result side: random stalls, then compare each word with the oldest owed result.
    initial
    begin
        int stall;
        table_result_t want;
        status_t got_status;
        logic [4:0] got_position;
        logic [4:0] got_count;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet_phase ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            got_status = status_t'(m_tdata[2:0]);
            got_position = m_tdata[7:3];
            got_count = m_tdata[12:8];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result word with nothing owed: status %0d position %0d count %0d",
                             $realtime, got_status, got_position, got_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got_status != want.status || got_position != want.position ||
                    got_count != want.entry_count)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: mismatch: expected status %0d position %0d count %0d, got status %0d position %0d count %0d",
                                 $realtime, want.status, want.position, want.entry_count,
                                 got_status, got_position, got_count);
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("keyed_list_table_unit verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ===== files.f =====
hdl/klt_pkg.sv
hdl/klt_ctrl.sv
hdl/klt_datapath.sv
hdl/keyed_list_table_unit.sv
tb/keyed_list_table_unit_tb.sv
